FILE: rtl/tbcpu_pkg.sv
// Package: payload types, command codes, state encoding and constants for the step unit.
package tbcpu_pkg;

  localparam int MemoryWordsDefault = 4096;
  localparam logic [11:0] StartReset = 12'o0200;

  typedef enum logic [1:0] {
    CMD_ORIGIN  = 2'd0,
    CMD_DEPOSIT = 2'd1,
    CMD_START   = 2'd2,
    CMD_EXEC    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_AND = 3'd0,
    OP_TAD = 3'd1,
    OP_ISZ = 3'd2,
    OP_DCA = 3'd3,
    OP_JMS = 3'd4,
    OP_JMP = 3'd5,
    OP_IOT = 3'd6,
    OP_OPR = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_PTR,
    ST_AUTO,
    ST_OPER,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] word_value;
  } in_item_t;

  typedef struct packed {
    logic [11:0] program_counter_out;
    logic [11:0] accumulator_out;
    logic        link_out;
    logic        halted_out;
    logic [2:0]  opcode_out;
    logic [11:0] effective_address_out;
    logic [11:0] operand_out;
  } out_item_t;

endpackage

FILE: rtl/tbcpu_ram.sv
// Generic single-port RAM with registered read.
module tbcpu_ram #(
  parameter int Width = 12,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/twelve_bit_cpu_instruction_step_unit.sv
// Top level: twelve-bit CPU instruction step unit with one memory port.
//
// channel   | signals                      | handshake
// ----------+------------------------------+--------------------------------
// command   | start, busy, in_item         | taken when start && !busy
// result    | done, out_item               | one-cycle strobe, no back-pressure
//
// After reset a clearing pass writes zero to every memory word, with busy high.
// Load, start and halted execute items go from accept straight to result. An
// operate or IOT execute steps through accept, decode and result; a memory reference
// through accept with fetch read, decode, operand and result, with a pointer step
// for an indirect address and an auto-index update step; all accesses share one port.
// busy stays high until the result cycle ends; the receiver cannot stall.
module twelve_bit_cpu_instruction_step_unit
  import tbcpu_pkg::*;
#(
  parameter int MemoryWords = MemoryWordsDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      done,
  output out_item_t out_item
);

  localparam int Aw = $clog2(MemoryWords);

  state_t      state, state_next;
  logic        clearing;
  logic [Aw-1:0] clr_cnt;
  logic [11:0] pc, acc, start_addr, ea, operand, wdata;
  logic        link, halted, origin_seen;
  opcode_t     op;
  logic        we;
  logic [11:0] maddr;
  logic [11:0] rdata;
  opcode_t     fetch_op;
  logic [11:0] ea_dir;
  logic        grp2_cond;
  logic        skip;
  logic        auto_hit;
  logic [11:0] rdata_inc;
  logic [12:0] tad_sum;
  logic [12:0] grp1_res;

  function automatic logic [12:0] grp1(logic [11:0] i, logic [11:0] a, logic l);
    logic [11:0] ac;
    logic        lk;
    logic [12:0] s;
    ac = a;
    lk = l;
    if (i[7]) ac = 12'd0;
    if (i[6]) lk = 1'b0;
    if (i[5]) ac = ~ac;
    if (i[4]) lk = ~lk;
    if (i[0]) begin
      s = {1'b0, ac} + 13'd1;
      if (s[12]) lk = ~lk;
      ac = s[11:0];
    end
    if (i[3]) begin
      {ac, lk} = {lk, ac};
      if (i[1]) {ac, lk} = {lk, ac};
    end
    if (i[2]) begin
      {lk, ac} = {ac, lk};
      if (i[1]) {lk, ac} = {ac, lk};
    end
    return {lk, ac};
  endfunction

  tbcpu_ram #(.Width(12), .Depth(MemoryWords)) u_ram (
    .clk  (clk),
    .we   (we),
    .addr (maddr[Aw-1:0]),
    .wdata(wdata),
    .rdata(rdata)
  );

  assign busy = clearing || (state != ST_IDLE);
  assign done = (state == ST_DONE);

  assign fetch_op  = opcode_t'(rdata[11:9]);
  assign ea_dir    = {(rdata[7] ? pc[11:7] : 5'd0), rdata[6:0]};
  assign grp2_cond = (rdata[6] && acc[11]) || (rdata[5] && acc == 12'd0) ||
                     (rdata[4] && link);
  assign skip      = (fetch_op == OP_OPR) && rdata[8] && !rdata[0] &&
                     (grp2_cond != rdata[3]);
  assign auto_hit  = (ea[11:3] == 9'o001);
  assign rdata_inc = rdata + 12'd1;
  assign tad_sum   = {1'b0, acc} + {1'b0, rdata};
  assign grp1_res  = grp1(rdata, acc, link);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start && !clearing) begin
        if (in_item.command == CMD_EXEC && !halted) state_next = ST_FETCH;
        else state_next = ST_DONE;
      end
      ST_FETCH: begin
        if (fetch_op == OP_IOT || fetch_op == OP_OPR) state_next = ST_DONE;
        else if (rdata[8]) state_next = ST_PTR;
        else state_next = ST_OPER;
      end
      ST_PTR:   state_next = auto_hit ? ST_AUTO : ST_OPER;
      ST_AUTO:  state_next = ST_OPER;
      ST_OPER:  state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    maddr = pc;
    wdata = 12'd0;
    if (clearing) begin
      we = 1'b1;
      maddr = 12'(clr_cnt);
    end else begin
      unique case (state)
        ST_IDLE: begin
          maddr = pc;
          if (start && in_item.command == CMD_DEPOSIT) begin
            we = 1'b1;
            wdata = in_item.word_value;
          end
        end
        ST_FETCH: maddr = ea_dir;
        ST_PTR: begin
          if (auto_hit) begin
            maddr = ea;
            we = 1'b1;
            wdata = rdata_inc;
          end else begin
            maddr = rdata;
          end
        end
        ST_AUTO: maddr = ea;
        ST_OPER: begin
          maddr = ea;
          unique case (op)
            OP_ISZ: begin we = 1'b1; wdata = rdata_inc; end
            OP_DCA: begin we = 1'b1; wdata = acc; end
            OP_JMS: begin we = 1'b1; wdata = pc; end
            default: ;
          endcase
        end
        default: maddr = pc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      clearing <= 1'b1;
      clr_cnt <= '0;
      pc <= 12'd0;
      acc <= 12'd0;
      link <= 1'b0;
      halted <= 1'b0;
      start_addr <= StartReset;
      origin_seen <= 1'b0;
      op <= OP_AND;
      ea <= 12'd0;
      operand <= 12'd0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == Aw'(MemoryWords - 1)) clearing <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (start && !clearing) begin
          op <= OP_AND;
          ea <= 12'd0;
          operand <= 12'd0;
          unique case (cmd_t'(in_item.command))
            CMD_ORIGIN: begin
              pc <= in_item.word_value;
              if (!origin_seen) begin
                start_addr <= in_item.word_value;
                origin_seen <= 1'b1;
              end
            end
            CMD_DEPOSIT: pc <= pc + 12'd1;
            CMD_START: begin
              pc <= start_addr;
              halted <= 1'b0;
            end
            default: ;
          endcase
        end
        ST_FETCH: begin
          op <= fetch_op;
          pc <= skip ? pc + 12'd2 : pc + 12'd1;
          if (fetch_op == OP_OPR) begin
            if (!rdata[8]) begin
              {link, acc} <= grp1_res;
            end else begin
              if (rdata[7]) acc <= 12'd0;
              if (!rdata[0] && rdata[1]) halted <= 1'b1;
            end
          end else if (fetch_op != OP_IOT) begin
            ea <= ea_dir;
          end
        end
        ST_PTR: ea <= auto_hit ? rdata_inc : rdata;
        ST_OPER: begin
          operand <= rdata;
          unique case (op)
            OP_AND: acc <= acc & rdata;
            OP_TAD: begin
              acc <= tad_sum[11:0];
              if (tad_sum[12]) link <= ~link;
            end
            OP_ISZ: if (rdata_inc == 12'd0) pc <= pc + 12'd1;
            OP_DCA: acc <= 12'd0;
            OP_JMS: pc <= ea + 12'd1;
            OP_JMP: pc <= ea;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign out_item = '{
    program_counter_out:   pc,
    accumulator_out:       acc,
    link_out:              link,
    halted_out:            halted,
    opcode_out:            op,
    effective_address_out: ea,
    operand_out:           operand
  };

endmodule

FILE: dv/tbcpu_checker.sv
// Checker: predicts each step result of the CPU step unit and compares it with the block.
module tbcpu_checker
  import tbcpu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      done,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [11:0] mem [0:4095];
  logic [11:0] pc, ac, start_addr;
  logic        lnk, halted, origin_seen;
  out_item_t   expected_q[$];

  function automatic void rot_right();
    logic b;
    b = ac[0];
    ac = {lnk, ac[11:1]};
    lnk = b;
  endfunction

  function automatic void rot_left();
    logic b;
    b = ac[11];
    ac = {ac[10:0], lnk};
    lnk = b;
  endfunction

  function automatic void run_operate(logic [11:0] inst);
    logic cond;
    logic [12:0] s;
    if (!inst[8]) begin
      if (inst[7]) ac = '0;
      if (inst[6]) lnk = 1'b0;
      if (inst[5]) ac = ~ac;
      if (inst[4]) lnk = ~lnk;
      if (inst[0]) begin
        s = {1'b0, ac} + 13'd1;
        if (s[12]) lnk = ~lnk;
        ac = s[11:0];
      end
      if (inst[3]) begin
        rot_right();
        if (inst[1]) rot_right();
      end
      if (inst[2]) begin
        rot_left();
        if (inst[1]) rot_left();
      end
    end else if (!inst[0]) begin
      cond = (inst[6] && ac[11]) || (inst[5] && ac == 0) || (inst[4] && lnk);
      if (inst[3]) cond = !cond;
      if (cond) pc = pc + 12'd1;
      if (inst[7]) ac = '0;
      if (inst[1]) halted = 1'b1;
    end else if (inst[7]) begin
      ac = '0;
    end
  endfunction

  function automatic out_item_t step_cpu(in_item_t it);
    out_item_t r;
    logic [11:0] here, inst, ea, opnd, t;
    logic [12:0] s;
    opcode_t op;
    op = OP_AND;
    ea = '0;
    opnd = '0;
    case (cmd_t'(it.command))
      CMD_ORIGIN: begin
        pc = it.word_value;
        if (!origin_seen) begin
          start_addr = it.word_value;
          origin_seen = 1'b1;
        end
      end
      CMD_DEPOSIT: begin
        mem[pc] = it.word_value;
        pc = pc + 12'd1;
      end
      CMD_START: begin
        pc = start_addr;
        halted = 1'b0;
      end
      default: begin
        if (!halted) begin
          here = pc;
          inst = mem[here];
          op = opcode_t'(inst[11:9]);
          pc = here + 12'd1;
          if (op != OP_IOT && op != OP_OPR) begin
            ea = {5'd0, inst[6:0]};
            if (inst[7]) ea[11:7] = here[11:7];
            if (inst[8]) begin
              if (ea[11:3] == 9'd1) mem[ea] = mem[ea] + 12'd1;
              ea = mem[ea];
            end
            opnd = mem[ea];
            case (op)
              OP_AND: ac = ac & opnd;
              OP_TAD: begin
                s = {1'b0, ac} + {1'b0, opnd};
                if (s[12]) lnk = ~lnk;
                ac = s[11:0];
              end
              OP_ISZ: begin
                t = opnd + 12'd1;
                mem[ea] = t;
                if (t == 0) pc = pc + 12'd1;
              end
              OP_DCA: begin
                mem[ea] = ac;
                ac = '0;
              end
              OP_JMS: begin
                mem[ea] = pc;
                pc = ea + 12'd1;
              end
              default: pc = ea;
            endcase
          end else if (op == OP_OPR) begin
            run_operate(inst);
          end
        end
      end
    endcase
    r.program_counter_out = pc;
    r.accumulator_out = ac;
    r.link_out = lnk;
    r.halted_out = halted;
    r.opcode_out = op;
    r.effective_address_out = ea;
    r.operand_out = opnd;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < 4096; i++) mem[i] = '0;
      pc = '0;
      ac = '0;
      lnk = 1'b0;
      halted = 1'b0;
      start_addr = StartReset;
      origin_seen = 1'b0;
      fail_count <= 0;
      pending <= 0;
      expected_q.delete();
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== out_item) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_item);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) expected_q.insert(expected_q.size(), step_cpu(in_item));
      pending <= expected_q.size();
    end
  end
endmodule

FILE: dv/tb_top.sv
// Testbench top: drives commands and programs into the CPU step unit and reports the verdict.
module tb_top
  import tbcpu_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk, rst, start, busy, done;
  in_item_t  in_item;
  out_item_t out_item;
  int        fail_count, pending, idle_cycles, sent;

  twelve_bit_cpu_instruction_step_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .busy(busy), .done(done), .out_item(out_item)
  );

  tbcpu_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .done(done), .out_item(out_item), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(cmd_t c, logic [11:0] w);
    start <= 1'b1;
    in_item <= '{command: c, word_value: w};
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [11:0] rand_inst();
    logic [11:0] w;
    w = 12'($urandom);
    case ($urandom_range(0, 5))
      0: w[8] = 1'b1;
      1: w[8:3] = 6'b100001;
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    int len;
    logic [11:0] base;
    rst = 1'b1;
    start = 1'b0;
    in_item = '0;
    sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send(CMD_EXEC, 12'o7777);
    send(CMD_ORIGIN, 12'o0007);
    send(CMD_DEPOSIT, 12'o0100);
    send(CMD_DEPOSIT, 12'o7777);
    send(CMD_ORIGIN, 12'o0200);
    send(CMD_DEPOSIT, 12'o7240);
    send(CMD_DEPOSIT, 12'o1410);
    send(CMD_DEPOSIT, 12'o2210);
    send(CMD_DEPOSIT, 12'o3377);
    send(CMD_DEPOSIT, 12'o7061);
    send(CMD_DEPOSIT, 12'o7016);
    send(CMD_DEPOSIT, 12'o7510);
    send(CMD_DEPOSIT, 12'o6000);
    send(CMD_DEPOSIT, 12'o4300);
    send(CMD_DEPOSIT, 12'o7402);
    send(CMD_START, 12'o0000);
    repeat (10) send(CMD_EXEC, 12'o0000);
    send(CMD_START, 12'hFFF);
    pause(3);
    while (pending != 0) @(posedge clk);
    while (sent < 1350) begin
      len = $urandom_range(1, 40);
      if ($urandom_range(0, 3) == 0) begin
        base = 12'($urandom);
        send(CMD_ORIGIN, base);
        repeat ($urandom_range(1, 12)) send(CMD_DEPOSIT, rand_inst());
        send(CMD_ORIGIN, base);
      end
      if ($urandom_range(0, 4) == 0) send(CMD_START, 12'($urandom));
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 15))
          0: send(CMD_ORIGIN, 12'($urandom));
          1: send(CMD_DEPOSIT, rand_inst());
          2: send(CMD_START, 12'($urandom));
          default: send(CMD_EXEC, 12'($urandom));
        endcase
      end
      if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 15));
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/tbcpu_pkg.sv
rtl/tbcpu_ram.sv
rtl/twelve_bit_cpu_instruction_step_unit.sv
dv/tbcpu_checker.sv
dv/tb_top.sv
